// ===== hw/rtl/correspondence_pair_consistency_unit_defines.svh =====
// Assertion macros used by the correspondence pair consistency RTL.
`ifndef CORRESPONDENCE_PAIR_CONSISTENCY_UNIT_DEFINES_SVH
`define CORRESPONDENCE_PAIR_CONSISTENCY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpc assertion failed");

// next-cycle implication
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpc assertion failed");

`else

`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/cpc_pkg.sv =====
// Types, constants and arithmetic helpers of the correspondence pair consistency unit.
`default_nettype none

package cpc_pkg;

    localparam int COORD_W     = 16;
    localparam int PT_W        = 3 * COORD_W;
    localparam int KP_W        = 2 * COORD_W;
    localparam int TAG_W       = 10;
    localparam int SPAN_W      = 15;
    localparam int ERR_W       = 12;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_OBJECT_SPAN  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ERROR = 1'd1;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 15'd1229;
    localparam logic [ERR_W-1:0]  ERR_RESET  = 12'd41;

    localparam int REACH_W  = 16;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST2_W  = SQ_W + 2;
    localparam int KP2_W    = SQ_W + 1;
    localparam int ROOT_W   = DIST2_W / 2;
    localparam int REM_W    = ROOT_W + 3;

    localparam int SQRT_STEPS           = ROOT_W;
    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES          =
        (SQRT_STEPS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;

    // 20 pixels, squared, in Q24.8
    localparam logic [KP2_W-1:0] KP_MIN_DIST_SQ = KP2_W'(20 * 20 * 256);

    typedef struct packed {
        logic [TAG_W-1:0] index_a;
        logic [TAG_W-1:0] index_b;
        logic [PT_W-1:0]  query_point_a;
        logic [PT_W-1:0]  query_point_b;
        logic [PT_W-1:0]  training_point_a;
        logic [PT_W-1:0]  training_point_b;
        logic [KP_W-1:0]  keypoint_a;
        logic [KP_W-1:0]  keypoint_b;
    } pair_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag_a;
        logic [TAG_W-1:0] tag_b;
        logic             physical_adjacent;
        logic             sample_adjacent;
    } verdict_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag_a;
        logic [TAG_W-1:0] tag_b;
        logic             in_reach;
        logic             kp_far;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [DIST2_W-1:0] dq2;
        logic [DIST2_W-1:0] dt2;
    } sq_req_t;

    typedef struct packed {
        side_t             side;
        logic [ROOT_W-1:0] dq;
        logic [ROOT_W-1:0] dt;
    } root_req_t;

    typedef struct packed {
        logic [DIST2_W-1:0] x;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_lane_t;

    function automatic logic [COORD_W-1:0] coord_dist(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            d = -d;
        end
        return d[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] pixel_dist(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic sqrt_lane_t sqrt_init(input logic [DIST2_W-1:0] x);
        sqrt_lane_t r;
        r.x    = x;
        r.rem  = '0;
        r.root = '0;
        return r;
    endfunction

    // one restoring digit: bring down two bits, try (root << 2) | 1
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t s);
        sqrt_lane_t       r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        cur   = {s.rem[REM_W-3:0], s.x[DIST2_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.x   = {s.x[DIST2_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sqrt_lane_t sqrt_steps(input sqrt_lane_t s, input int unsigned n);
        sqrt_lane_t r;
        r = s;
        for (int i = 0; i < SQRT_STEPS_PER_STAGE; i++)
        begin
            if (i < n)
            begin
                r = sqrt_step(r);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/correspondence_pair_consistency_unit.sv =====
// Top level of the correspondence pair consistency unit.
//
// Each request on the pair channel holds two 3D correspondences (query point,
// training point, image keypoint and a tag each). The unit returns one request
// on the verdict channel per pair, in order: both tags and the physical and
// sample adjacency bits. Both channels use valid/stall; a request moves when
// valid is high and stall is low.
// A pair passes the difference, square and sum stages, then the square-root
// stages (two result bits per stage, one in the last, for the 17-bit roots)
// and then the tolerance compare stage.
// Throughput is one pair per cycle when no stall holds the pipeline; every stage
// holds one pair. A stalled verdict holds its stage; stages behind it keep
// filling bubbles, and pair_stall rises only once every stage is full.
// Reset empties the pipeline and loads the span register with 1229 and the
// error register with 41. Write registers through cfg_write/cfg_index/cfg_data
// only while no pair is in flight.
`default_nettype none
`include "correspondence_pair_consistency_unit_defines.svh"

module correspondence_pair_consistency_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            pair_valid,
    output logic                                 pair_stall,
    input  wire cpc_pkg::pair_t                  pair,
    output logic                                 verdict_valid,
    input  wire logic                            verdict_stall,
    output cpc_pkg::verdict_t                    verdict
);
    import cpc_pkg::*;

    logic [SPAN_W-1:0] span_reg;
    logic [ERR_W-1:0]  err_reg;

    logic      sq_valid;
    logic      sq_stall;
    sq_req_t   sq_req;
    logic      rt_valid;
    logic      rt_stall;
    root_req_t rt_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
            err_reg  <= ERR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OBJECT_SPAN:  span_reg <= cfg_data[SPAN_W-1:0];
                REG_SENSOR_ERROR: err_reg  <= cfg_data[ERR_W-1:0];
            endcase
        end
    end

    cpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_limit (span_reg),
        .err_limit  (err_reg),
        .up_valid   (pair_valid),
        .up_stall   (pair_stall),
        .up_req     (pair),
        .dn_valid   (sq_valid),
        .dn_stall   (sq_stall),
        .dn_req     (sq_req)
    );

    cpc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sq_valid),
        .up_stall (sq_stall),
        .up_req   (sq_req),
        .dn_valid (rt_valid),
        .dn_stall (rt_stall),
        .dn_req   (rt_req)
    );

    cpc_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .err_limit (err_reg),
        .up_valid  (rt_valid),
        .up_stall  (rt_stall),
        .up_req    (rt_req),
        .dn_valid  (verdict_valid),
        .dn_stall  (verdict_stall),
        .dn_req    (verdict)
    );

    `CPC_ASSERT_IMPLY(a_sample_needs_physical, clk, rst_n, verdict_valid && verdict.sample_adjacent, verdict.physical_adjacent)
    `CPC_ASSERT_IMPLY(a_zero_error_no_sample, clk, rst_n, verdict_valid && (err_reg == '0), !verdict.sample_adjacent)
    `CPC_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, pair_stall, verdict_valid && verdict_stall)
    `CPC_ASSERT_NEXT(a_stall_keeps_verdict, clk, rst_n, pair_stall, verdict_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/cpc_front.sv =====
// Front stages: coordinate differences, squares, distance sums, reach and keypoint tests.
`default_nettype none

module cpc_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [cpc_pkg::SPAN_W-1:0] span_limit,
    input  wire logic [cpc_pkg::ERR_W-1:0]  err_limit,
    input  wire logic                       up_valid,
    output logic                            up_stall,
    input  wire cpc_pkg::pair_t             up_req,
    output logic                            dn_valid,
    input  wire logic                       dn_stall,
    output cpc_pkg::sq_req_t                dn_req
);
    import cpc_pkg::*;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_hold;
    logic s2_hold;
    logic s3_hold;

    logic [TAG_W-1:0]              s1_tag_a_reg;
    logic [TAG_W-1:0]              s1_tag_b_reg;
    logic [2:0][COORD_W-1:0]       s1_qd_reg;
    logic [2:0][COORD_W-1:0]       s1_qd_next;
    logic [2:0][COORD_W-1:0]       s1_td_reg;
    logic [2:0][COORD_W-1:0]       s1_td_next;
    logic [1:0][COORD_W-1:0]       s1_kd_reg;
    logic [1:0][COORD_W-1:0]       s1_kd_next;
    logic [REACH_W-1:0]            s1_reach_reg;
    logic [REACH_W-1:0]            s1_reach_next;

    logic [TAG_W-1:0]              s2_tag_a_reg;
    logic [TAG_W-1:0]              s2_tag_b_reg;
    logic [2:0][SQ_W-1:0]          s2_qs_reg;
    logic [2:0][SQ_W-1:0]          s2_qs_next;
    logic [2:0][SQ_W-1:0]          s2_ts_reg;
    logic [2:0][SQ_W-1:0]          s2_ts_next;
    logic [1:0][SQ_W-1:0]          s2_ks_reg;
    logic [1:0][SQ_W-1:0]          s2_ks_next;
    logic [SQ_W-1:0]               s2_reach_sq_reg;
    logic [SQ_W-1:0]               s2_reach_sq_next;

    sq_req_t                       s3_req_reg;
    sq_req_t                       s3_req_next;
    logic [KP2_W-1:0]              kp2;

    assign s3_hold  = s3_valid_reg && dn_stall;
    assign s2_hold  = s2_valid_reg && s3_hold;
    assign s1_hold  = s1_valid_reg && s2_hold;
    assign up_stall = s1_hold;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_qd_next[i] = coord_dist(up_req.query_point_a[i*COORD_W +: COORD_W],
                                       up_req.query_point_b[i*COORD_W +: COORD_W]);
            s1_td_next[i] = coord_dist(up_req.training_point_a[i*COORD_W +: COORD_W],
                                       up_req.training_point_b[i*COORD_W +: COORD_W]);
        end
        for (int i = 0; i < 2; i++)
        begin
            s1_kd_next[i] = pixel_dist(up_req.keypoint_a[i*COORD_W +: COORD_W],
                                       up_req.keypoint_b[i*COORD_W +: COORD_W]);
        end
        s1_reach_next = REACH_W'(span_limit) + REACH_W'({err_limit, 1'b0});
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_qs_next[i] = SQ_W'(s1_qd_reg[i]) * SQ_W'(s1_qd_reg[i]);
            s2_ts_next[i] = SQ_W'(s1_td_reg[i]) * SQ_W'(s1_td_reg[i]);
        end
        for (int i = 0; i < 2; i++)
        begin
            s2_ks_next[i] = SQ_W'(s1_kd_reg[i]) * SQ_W'(s1_kd_reg[i]);
        end
        s2_reach_sq_next = SQ_W'(s1_reach_reg) * SQ_W'(s1_reach_reg);
    end

    always_comb
    begin
        s3_req_next.dq2 = DIST2_W'(s2_qs_reg[0]) + DIST2_W'(s2_qs_reg[1])
                        + DIST2_W'(s2_qs_reg[2]);
        s3_req_next.dt2 = DIST2_W'(s2_ts_reg[0]) + DIST2_W'(s2_ts_reg[1])
                        + DIST2_W'(s2_ts_reg[2]);
        kp2             = KP2_W'(s2_ks_reg[0]) + KP2_W'(s2_ks_reg[1]);
        s3_req_next.side.tag_a    = s2_tag_a_reg;
        s3_req_next.side.tag_b    = s2_tag_b_reg;
        s3_req_next.side.in_reach = (s3_req_next.dq2 <= DIST2_W'(s2_reach_sq_reg));
        s3_req_next.side.kp_far   = (kp2 > KP_MIN_DIST_SQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_valid_reg <= up_valid;
            end
            if (!s2_hold)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!s3_hold)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_hold)
        begin
            s1_tag_a_reg <= up_req.index_a;
            s1_tag_b_reg <= up_req.index_b;
            s1_qd_reg    <= s1_qd_next;
            s1_td_reg    <= s1_td_next;
            s1_kd_reg    <= s1_kd_next;
            s1_reach_reg <= s1_reach_next;
        end
        if (!s2_hold)
        begin
            s2_tag_a_reg    <= s1_tag_a_reg;
            s2_tag_b_reg    <= s1_tag_b_reg;
            s2_qs_reg       <= s2_qs_next;
            s2_ts_reg       <= s2_ts_next;
            s2_ks_reg       <= s2_ks_next;
            s2_reach_sq_reg <= s2_reach_sq_next;
        end
        if (!s3_hold)
        begin
            s3_req_reg <= s3_req_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign dn_req   = s3_req_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cpc_isqrt.sv =====
// Pipelined integer square root of both squared distances, two digits per stage.
`default_nettype none

module cpc_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    output logic             up_stall,
    input  wire cpc_pkg::sq_req_t   up_req,
    output logic             dn_valid,
    input  wire logic        dn_stall,
    output cpc_pkg::root_req_t      dn_req
);
    import cpc_pkg::*;

    localparam int LAST = SQRT_STAGES - 1;

    logic       v_reg    [SQRT_STAGES];
    logic       hold     [SQRT_STAGES];
    sqrt_lane_t q_reg    [SQRT_STAGES];
    sqrt_lane_t t_reg    [SQRT_STAGES];
    side_t      side_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam int FIRST  = k * SQRT_STEPS_PER_STAGE;
        localparam int NSTEPS = (SQRT_STEPS - FIRST < SQRT_STEPS_PER_STAGE)
                              ? (SQRT_STEPS - FIRST) : SQRT_STEPS_PER_STAGE;

        logic       valid_in;
        sqrt_lane_t q_in;
        sqrt_lane_t t_in;
        side_t      side_in;
        sqrt_lane_t q_next;
        sqrt_lane_t t_next;

        if (k == 0)
        begin : g_head
            assign valid_in = up_valid;
            assign q_in     = sqrt_init(up_req.dq2);
            assign t_in     = sqrt_init(up_req.dt2);
            assign side_in  = up_req.side;
        end
        else
        begin : g_body
            assign valid_in = v_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign t_in     = t_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        if (k == LAST)
        begin : g_tail
            assign hold[k] = v_reg[k] && dn_stall;
        end
        else
        begin : g_mid
            assign hold[k] = v_reg[k] && hold[k+1];
        end

        always_comb
        begin
            q_next = sqrt_steps(q_in, NSTEPS);
            t_next = sqrt_steps(t_in, NSTEPS);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (!hold[k])
            begin
                v_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!hold[k])
            begin
                q_reg[k]    <= q_next;
                t_reg[k]    <= t_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign up_stall    = hold[0];
    assign dn_valid    = v_reg[LAST];
    assign dn_req.side = side_reg[LAST];
    assign dn_req.dq   = q_reg[LAST].root;
    assign dn_req.dt   = t_reg[LAST].root;

endmodule

`default_nettype wire

// ===== hw/rtl/cpc_judge.sv =====
// Final stage: distance mismatch against tolerances and the result register.
`default_nettype none

module cpc_judge (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [cpc_pkg::ERR_W-1:0] err_limit,
    input  wire logic                      up_valid,
    output logic                           up_stall,
    input  wire cpc_pkg::root_req_t        up_req,
    output logic                           dn_valid,
    input  wire logic                      dn_stall,
    output cpc_pkg::verdict_t              dn_req
);
    import cpc_pkg::*;

    logic              out_valid_reg;
    logic              hold;
    verdict_t          out_reg;
    verdict_t          out_next;
    logic [ROOT_W-1:0] mismatch;
    logic              phys;

    assign hold     = out_valid_reg && dn_stall;
    assign up_stall = hold;

    always_comb
    begin
        mismatch = (up_req.dt >= up_req.dq) ? (up_req.dt - up_req.dq)
                                            : (up_req.dq - up_req.dt);
        phys     = up_req.side.in_reach && (mismatch <= ROOT_W'({err_limit, 2'b00}));
        out_next.tag_a             = up_req.side.tag_a;
        out_next.tag_b             = up_req.side.tag_b;
        out_next.physical_adjacent = phys;
        out_next.sample_adjacent   = phys && up_req.side.kp_far
                                   && (mismatch < ROOT_W'({err_limit, 1'b0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            out_reg <= out_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_req   = out_reg;

endmodule

`default_nettype wire

// ===== sim/pair_verdict_checker.sv =====
// Checker that predicts each verdict from the accepted pair requests and compares it with the unit.
`timescale 1ns / 1ps

module pair_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pair_valid,
    input  logic                            pair_stall,
    input  cpc_pkg::pair_t                  pair,
    input  logic                            verdict_valid,
    input  logic                            verdict_stall,
    input  cpc_pkg::verdict_t               verdict,
    output int                              mismatches,
    output int                              outstanding
);
    import cpc_pkg::*;

    logic [SPAN_W-1:0] span_copy;
    logic [ERR_W-1:0]  err_copy;
    verdict_t          awaited_verdicts[$];
    verdict_t          wanted;

    function automatic longint unsigned point_gap_sq(input logic [PT_W-1:0] a,
                                                     input logic [PT_W-1:0] b);
        longint unsigned acc;
        longint          d;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            d   = longint'($signed(a[16*k +: 16])) - longint'($signed(b[16*k +: 16]));
            acc = acc + 64'(d * d);
        end
        return acc;
    endfunction

    function automatic longint unsigned keypoint_gap_sq(input logic [KP_W-1:0] a,
                                                        input logic [KP_W-1:0] b);
        longint unsigned acc;
        longint unsigned va;
        longint unsigned vb;
        acc = 0;
        for (int k = 0; k < 2; k++)
        begin
            va  = 64'(a[16*k +: 16]);
            vb  = 64'(b[16*k +: 16]);
            acc = acc + ((va > vb) ? (va - vb) * (va - vb) : (vb - va) * (vb - va));
        end
        return acc;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 18; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic verdict_t judge_pair(input pair_t p, input logic [SPAN_W-1:0] span,
                                            input logic [ERR_W-1:0] err);
        verdict_t        v;
        longint unsigned reach;
        longint unsigned dq2;
        longint unsigned dq;
        longint unsigned dt;
        longint unsigned gap;
        v.tag_a             = p.index_a;
        v.tag_b             = p.index_b;
        v.physical_adjacent = 1'b0;
        v.sample_adjacent   = 1'b0;
        reach = 64'(span) + 2 * 64'(err);
        dq2   = point_gap_sq(p.query_point_a, p.query_point_b);
        if (dq2 <= reach * reach)
        begin
            dq  = floor_root(dq2);
            dt  = floor_root(point_gap_sq(p.training_point_a, p.training_point_b));
            gap = (dt > dq) ? dt - dq : dq - dt;
            if (gap <= 4 * 64'(err))
            begin
                v.physical_adjacent = 1'b1;
                v.sample_adjacent   = (gap < 2 * 64'(err)) &&
                    (keypoint_gap_sq(p.keypoint_a, p.keypoint_b) > 64'(KP_MIN_DIST_SQ));
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_copy = SPAN_RESET;
            err_copy  = ERR_RESET;
            awaited_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_OBJECT_SPAN)
                begin
                    span_copy = cfg_data[SPAN_W-1:0];
                end
                else if (cfg_index == REG_SENSOR_ERROR)
                begin
                    err_copy = cfg_data[ERR_W-1:0];
                end
            end
            if (verdict_valid && !verdict_stall)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected verdict tags %0d/%0d phys %b samp %b", $time,
                                 verdict.tag_a, verdict.tag_b, verdict.physical_adjacent,
                                 verdict.sample_adjacent);
                    end
                end
                else
                begin
                    wanted = awaited_verdicts.pop_front();
                    if (verdict.tag_a !== wanted.tag_a || verdict.tag_b !== wanted.tag_b ||
                        verdict.physical_adjacent !== wanted.physical_adjacent ||
                        verdict.sample_adjacent !== wanted.sample_adjacent)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: verdict expected tags %0d/%0d phys %b samp %b, got tags %0d/%0d phys %b samp %b",
                                     $time, wanted.tag_a, wanted.tag_b,
                                     wanted.physical_adjacent, wanted.sample_adjacent,
                                     verdict.tag_a, verdict.tag_b,
                                     verdict.physical_adjacent, verdict.sample_adjacent);
                        end
                    end
                end
            end
            if (pair_valid && !pair_stall)
            begin
                awaited_verdicts.insert(awaited_verdicts.size(),
                                        judge_pair(pair, span_copy, err_copy));
            end
            outstanding = awaited_verdicts.size();
        end
    end

endmodule

// ===== sim/correspondence_pair_consistency_unit_test.sv =====
// Testbench top for the correspondence pair consistency unit: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module correspondence_pair_consistency_unit_test;
    import cpc_pkg::*;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = REG_OBJECT_SPAN;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   pair_valid    = 1'b0;
    logic                   pair_stall;
    pair_t                  pair          = '0;
    logic                   verdict_valid;
    logic                   verdict_stall = 1'b0;
    verdict_t               verdict;
    int                     mismatches;
    int                     outstanding;
    int                     sender_idle_pct    = 0;
    int                     receiver_stall_pct = 0;
    int                     span_now           = SPAN_RESET;
    int                     err_now            = ERR_RESET;

    correspondence_pair_consistency_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pair_valid    (pair_valid),
        .pair_stall    (pair_stall),
        .pair          (pair),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict)
    );

    pair_verdict_checker verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pair_valid    (pair_valid),
        .pair_stall    (pair_stall),
        .pair          (pair),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        verdict_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    function automatic logic [PT_W-1:0] pt(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [KP_W-1:0] kp(input int x, input int y);
        return {16'(y), 16'(x)};
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    function automatic pair_t random_pair(input int reach, input int err);
        pair_t p;
        int    r;
        int    slack;
        int    lim_q;
        int    lim_t;
        int    qd;
        int    td;
        int    base;
        p.index_a          = 10'($urandom);
        p.index_b          = 10'($urandom);
        p.query_point_a    = 48'({$urandom, $urandom});
        p.query_point_b    = 48'({$urandom, $urandom});
        p.training_point_a = 48'({$urandom, $urandom});
        p.training_point_b = 48'({$urandom, $urandom});
        p.keypoint_a       = 32'($urandom);
        p.keypoint_b       = 32'($urandom);
        if ($urandom_range(99) < 80)
        begin
            r     = reach * 3 / 5 + 1;
            slack = 3 * err + 2;
            lim_q = 32767 - r;
            lim_t = (r + slack < 32767) ? 32767 - r - slack : 0;
            for (int k = 0; k < 3; k++)
            begin
                qd = spread(r);
                td = qd + spread(slack);
                p.query_point_a[16*k +: 16]    = 16'(spread(lim_q));
                p.query_point_b[16*k +: 16]    = p.query_point_a[16*k +: 16] + 16'(qd);
                p.training_point_a[16*k +: 16] = 16'(spread(lim_t));
                p.training_point_b[16*k +: 16] = p.training_point_a[16*k +: 16] + 16'(td);
            end
            if ($urandom_range(99) < 70)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    base = 480 + int'($urandom_range(65535 - 960));
                    p.keypoint_a[16*k +: 16] = 16'(base);
                    p.keypoint_b[16*k +: 16] = 16'(base + spread(480));
                end
            end
        end
        return p;
    endfunction

    task automatic send_pair(input pair_t p);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(negedge clk);
        end
        pair       <= p;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (pair_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_pair(input int tag_a, input int tag_b,
                              input logic [PT_W-1:0] qa, input logic [PT_W-1:0] qb,
                              input logic [PT_W-1:0] ta, input logic [PT_W-1:0] tb,
                              input logic [KP_W-1:0] ka, input logic [KP_W-1:0] kb);
        pair_t p;
        p.index_a          = 10'(tag_a);
        p.index_b          = 10'(tag_b);
        p.query_point_a    = qa;
        p.query_point_b    = qb;
        p.training_point_a = ta;
        p.training_point_b = tb;
        p.keypoint_a       = ka;
        p.keypoint_b       = kb;
        send_pair(p);
    endtask

    task automatic drain();
        @(negedge clk);
        pair_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] span,
                              input logic [CFG_DATA_W-1:0] err_data);
        write_reg(REG_OBJECT_SPAN, span);
        write_reg(REG_SENSOR_ERROR, err_data);
        span_now = span;
        err_now  = err_data & 15'hFFF;
    endtask

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        offer_pair(0, 0, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(0, 0));
        offer_pair(1023, 1023, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(341, 682, pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                   pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(682, 341, pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                   pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                   kp(65535, 0), kp(0, 65535));
        offer_pair(1, 2, pt(1311, 0, 0), pt(0, 0, 0), pt(1311, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(3, 4, pt(1312, 0, 0), pt(0, 0, 0), pt(1312, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(5, 6, pt(0, 0, 0), pt(0, 0, -1311), pt(0, 0, 0), pt(0, -1311, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(7, 8, pt(0, 0, 0), pt(0, 0, 0), pt(164, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(9, 10, pt(0, 0, 0), pt(0, 0, 0), pt(165, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(11, 12, pt(0, 0, 0), pt(0, 0, 0), pt(0, 81, 0), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(13, 14, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 82), pt(0, 0, 0),
                   kp(0, 0), kp(65535, 65535));
        offer_pair(15, 16, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(320, 0));
        offer_pair(17, 18, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(0, 0), kp(321, 0));
        offer_pair(19, 20, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(1000, 5000), kp(1000, 4679));
        offer_pair(21, 22, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                   kp(65535, 65535), kp(65535, 65535));
        offer_pair(23, 24, pt(-500, -700, 300), pt(100, -200, -250),
                   pt(1000, 2000, -3000), pt(1600, 2480, -3560),
                   kp(100, 100), kp(9000, 9000));
        offer_pair(25, 26, pt(10, 20, 30), pt(-10, -20, -30),
                   pt(-32768, 0, 0), pt(32767, 0, 0), kp(0, 0), kp(65535, 65535));
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    set_limits(15'h7FFF, 15'h7FFF);
                    sender_idle_pct    = 68;
                    receiver_stall_pct = 0;
                    offer_pair(512, 513, pt(32767, 0, 0), pt(-8190, 0, 0),
                               pt(0, 0, 0), pt(40957, 0, 0), kp(0, 0), kp(65535, 65535));
                    offer_pair(514, 515, pt(32767, 1, 0), pt(-8190, 0, 0),
                               pt(0, 0, 0), pt(0, 0, 0), kp(0, 0), kp(65535, 65535));
                end
                2:
                begin
                    set_limits('0, '0);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 68;
                    offer_pair(600, 601, pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                               kp(0, 0), kp(65535, 65535));
                    offer_pair(602, 603, pt(0, 0, 0), pt(0, 0, 0), pt(1, 0, 0), pt(0, 0, 0),
                               kp(0, 0), kp(65535, 65535));
                end
                3:
                begin
                    set_limits(15'($urandom_range(32767)), 15'($urandom_range(4095)));
                    sender_idle_pct    = 37;
                    receiver_stall_pct = 37;
                end
                default:
                begin
                    set_limits(15'($urandom_range(4095)), 15'($urandom_range(300)));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            repeat (255)
            begin
                send_pair(random_pair(span_now + 2 * err_now, err_now));
            end
            drain();
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
